// ----- hdl/kfs_pkg.sv -----
// Shared types, constants and the microcode table of the Kalman filter step.
package kfs_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RAM_DEPTH = 32;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
  localparam int unsigned PC_W      = 6;

  typedef logic [RAM_AW-1:0] addr_t;
  typedef logic [PC_W-1:0]   pc_t;

  // Scratch memory layout.
  localparam addr_t RA_P  = addr_t'(0);
  localparam addr_t RA_XP = addr_t'(4);
  localparam addr_t RA_T  = addr_t'(6);
  localparam addr_t RA_PP = addr_t'(10);
  localparam addr_t RA_H  = addr_t'(14);
  localparam addr_t RA_K  = addr_t'(16);
  localparam addr_t RA_R  = addr_t'(18);
  localparam addr_t RA_M  = addr_t'(19);

  // Configuration register indexes.
  localparam logic [2:0] CFG_TRANSITION = 3'd0;
  localparam logic [2:0] CFG_MEAS_ROW   = 3'd1;
  localparam logic [2:0] CFG_PROC_NOISE = 3'd2;
  localparam logic [2:0] CFG_MEAS_NOISE = 3'd3;
  localparam logic [2:0] CFG_INIT_COV   = 3'd4;
  localparam logic [2:0] CFG_TIME_STEP  = 3'd5;

  // Request codes.
  localparam logic [1:0] REQ_MEASURE = 2'd0;
  localparam logic [1:0] REQ_INIT    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  typedef enum logic [1:0] {OP_MAC, OP_DIV, OP_END} kind_e;
  typedef enum logic [2:0] {SRC_RAM, SRC_A, SRC_C, SRC_X, SRC_INV, SRC_ONE} src_e;
  typedef enum logic [2:0] {ADD_NONE, ADD_Q, ADD_R, ADD_Y, ADD_ONE} add_e;
  typedef enum logic [1:0] {DST_RAM, DST_X, DST_S} dst_e;

  typedef struct packed {
    kind_e      kind;
    src_e       a_src;
    addr_t      a_idx;
    src_e       b_src;
    addr_t      b_idx;
    logic       first;
    logic       last;
    logic       sh16;
    add_e       add;
    logic [1:0] add_idx;
    logic       neg;
    dst_e       dst;
    addr_t      dst_idx;
  } uop_t;

  // Program segment starts.
  localparam pc_t PG_XP  = pc_t'(0);
  localparam pc_t PG_T   = pc_t'(4);
  localparam pc_t PG_PP  = pc_t'(12);
  localparam pc_t PG_H   = pc_t'(20);
  localparam pc_t PG_S   = pc_t'(24);
  localparam pc_t PG_DIV = pc_t'(26);
  localparam pc_t PG_K   = pc_t'(27);
  localparam pc_t PG_R   = pc_t'(29);
  localparam pc_t PG_X   = pc_t'(31);
  localparam pc_t PG_M   = pc_t'(35);
  localparam pc_t PG_PN  = pc_t'(39);
  localparam pc_t PG_END = pc_t'(47);

  // Signed Q8.8 entry k of a packed word, sign extended.
  function automatic logic signed [31:0] q88(input logic [63:0] w, input logic [1:0] k);
    logic [15:0] e;
    e = w[{k, 4'b0000} +: 16];
    return 32'(signed'(e));
  endfunction

  function automatic uop_t rom(input pc_t pc);
    uop_t u;
    pc_t  o;
    logic i, j, q;
    u.kind    = OP_MAC;
    u.a_src   = SRC_RAM;
    u.a_idx   = '0;
    u.b_src   = SRC_RAM;
    u.b_idx   = '0;
    u.first   = 1'b1;
    u.last    = 1'b1;
    u.sh16    = 1'b0;
    u.add     = ADD_NONE;
    u.add_idx = '0;
    u.neg     = 1'b0;
    u.dst     = DST_RAM;
    u.dst_idx = '0;
    o = '0;
    if (pc < PG_T) begin
      // Predicted state.
      o = pc - PG_XP;
      i = o[1];
      q = o[0];
      u.a_src   = SRC_A;
      u.a_idx   = addr_t'({i, q});
      u.b_src   = SRC_X;
      u.b_idx   = addr_t'(q);
      u.first   = ~q;
      u.last    = q;
      u.dst_idx = RA_XP + addr_t'(i);
    end else if (pc < PG_PP) begin
      o = pc - PG_T;
      i = o[2];
      j = o[1];
      q = o[0];
      u.a_src   = SRC_A;
      u.a_idx   = addr_t'({i, q});
      u.b_idx   = RA_P + addr_t'({q, j});
      u.first   = ~q;
      u.last    = q;
      u.dst_idx = RA_T + addr_t'({i, j});
    end else if (pc < PG_H) begin
      o = pc - PG_PP;
      i = o[2];
      j = o[1];
      q = o[0];
      u.a_idx   = RA_T + addr_t'({i, q});
      u.b_src   = SRC_A;
      u.b_idx   = addr_t'({j, q});
      u.first   = ~q;
      u.last    = q;
      u.add     = ADD_Q;
      u.add_idx = {i, j};
      u.dst_idx = RA_PP + addr_t'({i, j});
    end else if (pc < PG_S) begin
      o = pc - PG_H;
      i = o[1];
      j = o[0];
      u.a_idx   = RA_PP + addr_t'({i, j});
      u.b_src   = SRC_C;
      u.b_idx   = addr_t'(j);
      u.first   = ~j;
      u.last    = j;
      u.dst_idx = RA_H + addr_t'(i);
    end else if (pc < PG_DIV) begin
      o = pc - PG_S;
      q = o[0];
      u.a_src = SRC_C;
      u.a_idx = addr_t'(q);
      u.b_idx = RA_H + addr_t'(q);
      u.first = ~q;
      u.last  = q;
      u.add   = ADD_R;
      u.dst   = DST_S;
    end else if (pc < PG_K) begin
      u.kind = OP_DIV;
    end else if (pc < PG_R) begin
      o = pc - PG_K;
      i = o[0];
      u.a_idx   = RA_H + addr_t'(i);
      u.b_src   = SRC_INV;
      u.sh16    = 1'b1;
      u.dst_idx = RA_K + addr_t'(i);
    end else if (pc < PG_X) begin
      o = pc - PG_R;
      q = o[0];
      u.a_src   = SRC_C;
      u.a_idx   = addr_t'(q);
      u.b_idx   = RA_XP + addr_t'(q);
      u.first   = ~q;
      u.last    = q;
      u.neg     = 1'b1;
      u.add     = ADD_Y;
      u.dst_idx = RA_R;
    end else if (pc < PG_M) begin
      // The predicted state enters the sum scaled by one in Q16.16.
      o = pc - PG_X;
      i = o[1];
      q = o[0];
      u.a_idx   = q ? (RA_XP + addr_t'(i)) : (RA_K + addr_t'(i));
      u.b_src   = q ? SRC_ONE : SRC_RAM;
      u.b_idx   = RA_R;
      u.first   = ~q;
      u.last    = q;
      u.sh16    = 1'b1;
      u.dst     = DST_X;
      u.dst_idx = addr_t'(i);
    end else if (pc < PG_PN) begin
      o = pc - PG_M;
      i = o[1];
      j = o[0];
      u.a_idx   = RA_K + addr_t'(i);
      u.b_src   = SRC_C;
      u.b_idx   = addr_t'(j);
      u.neg     = 1'b1;
      u.add     = (i == j) ? ADD_ONE : ADD_NONE;
      u.dst_idx = RA_M + addr_t'({i, j});
    end else if (pc < PG_END) begin
      o = pc - PG_PN;
      i = o[2];
      j = o[1];
      q = o[0];
      u.a_idx   = RA_M + addr_t'({i, q});
      u.b_idx   = RA_PP + addr_t'({q, j});
      u.first   = ~q;
      u.last    = q;
      u.sh16    = 1'b1;
      u.dst_idx = RA_P + addr_t'({i, j});
    end else begin
      u.kind = OP_END;
    end
    return u;
  endfunction

endpackage

// ----- hdl/kalman_filter_step.sv -----
// Two-state fixed point Kalman filter step with one shared multiplier and divider.
// A measurement runs 46 multiply-accumulate steps (read, multiply, accumulate) on the
// single 32x32 multiplier, 26 write-backs and a 33-step divider. Initialize and restart
// load the initial covariance first. One request is in work at a time;
// the next is taken while a finished result still waits in the output register.
// Reset clears state, time and the initialized flag and loads register defaults.
module kalman_filter_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic signed [15:0]  measurement_i,
  input  logic signed [15:0]  initial_state_0_i,
  input  logic signed [15:0]  initial_state_1_i,
  input  logic [31:0]         start_time_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  estimate_0_o,
  output logic signed [31:0]  estimate_1_o,
  output logic [31:0]         elapsed_time_o,
  output logic                not_ready_o
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LOAD = 9'b000000010,
    ST_RD   = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_ACC  = 9'b000010000,
    ST_WB   = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_INV  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_e;

  localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

  state_e state_q, state_d;

  logic [63:0] tm_q, pn_q, ic_q;
  logic [31:0] mr_q;
  logic [15:0] mn_q, ts_q;

  logic signed [31:0] x_q [2];
  logic [31:0]        time_q, saved_q;
  logic               init_q;
  logic               nr_q;
  logic signed [15:0] y_q;

  kfs_pkg::pc_t pc_q;
  logic [1:0]   ld_cnt_q;
  logic [5:0]   dcnt_q;

  logic signed [63:0] prod_q;
  logic signed [65:0] acc_q;
  logic signed [31:0] s_q, inv_q;
  logic [31:0]        dvs_q, rem_q;
  logic [32:0]        quo_q;

  logic               out_valid_q;
  logic               in_fire, out_free;
  kfs_pkg::uop_t      uop;

  logic [31:0]        ram_rd_a, ram_rd_b, ram_wdata;
  kfs_pkg::addr_t     ram_waddr;
  logic               ram_we;

  logic signed [31:0] opa, opb, addend, fin;
  logic signed [65:0] shv;
  logic signed [67:0] total;
  logic [32:0]        trial;
  logic               div_bit;
  logic signed [31:0] inv_val;

  assign uop        = kfs_pkg::rom(pc_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  function automatic logic signed [31:0] opnd(input kfs_pkg::src_e src,
                                               input kfs_pkg::addr_t idx,
                                               input logic [31:0] ramv,
                                               input logic [63:0] tm,
                                               input logic [31:0] mr,
                                               input logic signed [31:0] x0,
                                               input logic signed [31:0] x1,
                                               input logic signed [31:0] inv);
    logic signed [31:0] v;
    case (src)
      kfs_pkg::SRC_RAM: v = signed'(ramv);
      kfs_pkg::SRC_A:   v = kfs_pkg::q88(tm, idx[1:0]);
      kfs_pkg::SRC_C:   v = kfs_pkg::q88({32'h0, mr}, {1'b0, idx[0]});
      kfs_pkg::SRC_X:   v = idx[0] ? x1 : x0;
      kfs_pkg::SRC_INV: v = inv;
      kfs_pkg::SRC_ONE: v = 32'sd65536;
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign opa = opnd(uop.a_src, uop.a_idx, ram_rd_a, tm_q, mr_q, x_q[0], x_q[1], inv_q);
  assign opb = opnd(uop.b_src, uop.b_idx, ram_rd_b, tm_q, mr_q, x_q[0], x_q[1], inv_q);

  // Write-back: floor shift, optional negation, addend, then saturation.
  always_comb begin
    case (uop.add)
      kfs_pkg::ADD_Q:   addend = kfs_pkg::q88(pn_q, uop.add_idx) <<< 8;
      kfs_pkg::ADD_R:   addend = signed'({8'h00, mn_q, 8'h00});
      kfs_pkg::ADD_Y:   addend = 32'(y_q) <<< 8;
      kfs_pkg::ADD_ONE: addend = 32'sd65536;
      default:          addend = '0;
    endcase
    shv   = uop.sh16 ? (acc_q >>> 16) : (acc_q >>> 8);
    total = 68'(addend) + (uop.neg ? -68'(shv) : 68'(shv));
    if (total > SAT_MAX) begin
      fin = 32'sh7FFFFFFF;
    end else if (total < SAT_MIN) begin
      fin = 32'sh80000000;
    end else begin
      fin = total[31:0];
    end
  end

  // Restoring division of 2^32 by the magnitude of the innovation variance.
  assign div_bit = (dcnt_q == 6'd32);
  assign trial   = {rem_q, div_bit};

  always_comb begin
    if (s_q == '0) begin
      inv_val = '0;
    end else if (!s_q[31]) begin
      inv_val = (quo_q[32] | quo_q[31]) ? 32'sh7FFFFFFF : signed'(quo_q[31:0]);
    end else if (quo_q > 33'h080000000) begin
      inv_val = 32'sh80000000;
    end else begin
      inv_val = signed'(-quo_q[31:0]);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = kfs_pkg::RA_P + kfs_pkg::addr_t'(ld_cnt_q);
    ram_wdata = 32'(kfs_pkg::q88(ic_q, ld_cnt_q) <<< 8);
    if (state_q == ST_LOAD) begin
      ram_we = 1'b1;
    end else if (state_q == ST_WB && uop.dst == kfs_pkg::DST_RAM) begin
      ram_we    = 1'b1;
      ram_waddr = uop.dst_idx;
      ram_wdata = fin;
    end
  end

  kfs_ram #(
    .WIDTH(kfs_pkg::DATA_W),
    .DEPTH(kfs_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(uop.a_idx),
    .raddr_b_i(uop.b_idx),
    .rdata_a_o(ram_rd_a),
    .rdata_b_o(ram_rd_b)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (req_type_i)
            kfs_pkg::REQ_MEASURE: state_d = init_q ? ST_RD : ST_OUT;
            kfs_pkg::REQ_INIT:    state_d = ST_LOAD;
            kfs_pkg::REQ_RESTART: state_d = ST_LOAD;
            default:              state_d = ST_OUT;
          endcase
        end
      end
      ST_LOAD: if (ld_cnt_q == 2'd3) state_d = ST_OUT;
      ST_RD: begin
        case (uop.kind)
          kfs_pkg::OP_DIV: state_d = ST_DIV;
          kfs_pkg::OP_END: state_d = ST_OUT;
          default:         state_d = ST_MUL;
        endcase
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = uop.last ? ST_WB : ST_RD;
      ST_WB:  state_d = ST_RD;
      ST_DIV: if (dcnt_q == '0) state_d = ST_INV;
      ST_INV: state_d = ST_RD;
      ST_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tm_q    <= '0;
      mr_q    <= '0;
      pn_q    <= '0;
      mn_q    <= 16'd256;
      ic_q    <= '0;
      ts_q    <= 16'd256;
      x_q[0]  <= '0;
      x_q[1]  <= '0;
      time_q  <= '0;
      saved_q <= '0;
      init_q  <= 1'b0;
      nr_q    <= 1'b0;
      pc_q    <= '0;
      ld_cnt_q <= '0;
      dcnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kfs_pkg::CFG_TRANSITION: tm_q <= cfg_data_i;
          kfs_pkg::CFG_MEAS_ROW:   mr_q <= cfg_data_i[31:0];
          kfs_pkg::CFG_PROC_NOISE: pn_q <= cfg_data_i;
          kfs_pkg::CFG_MEAS_NOISE: mn_q <= cfg_data_i[15:0];
          kfs_pkg::CFG_INIT_COV:   ic_q <= cfg_data_i;
          kfs_pkg::CFG_TIME_STEP:  ts_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        nr_q     <= (req_type_i == kfs_pkg::REQ_MEASURE) & ~init_q;
        pc_q     <= '0;
        ld_cnt_q <= '0;
        case (req_type_i)
          kfs_pkg::REQ_INIT: begin
            x_q[0]  <= 32'(initial_state_0_i) <<< 8;
            x_q[1]  <= 32'(initial_state_1_i) <<< 8;
            time_q  <= start_time_i;
            saved_q <= start_time_i;
            init_q  <= 1'b1;
          end
          kfs_pkg::REQ_RESTART: begin
            x_q[0] <= '0;
            x_q[1] <= '0;
            init_q <= 1'b1;
            if (init_q) begin
              time_q <= saved_q;
            end else begin
              time_q  <= '0;
              saved_q <= '0;
            end
          end
          default: ;
        endcase
      end

      if (state_q == ST_LOAD) begin
        ld_cnt_q <= ld_cnt_q + 2'd1;
      end
      if (state_q == ST_RD && uop.kind == kfs_pkg::OP_DIV) begin
        dcnt_q <= 6'd32;
      end
      if (state_q == ST_RD && uop.kind == kfs_pkg::OP_END) begin
        time_q <= time_q + {8'h00, ts_q, 8'h00};
      end
      if (state_q == ST_DIV) begin
        dcnt_q <= dcnt_q - 6'd1;
      end
      if ((state_q == ST_ACC && !uop.last) || state_q == ST_WB || state_q == ST_INV) begin
        pc_q <= pc_q + kfs_pkg::pc_t'(1);
      end
      if (state_q == ST_WB && uop.dst == kfs_pkg::DST_X) begin
        x_q[uop.dst_idx[0]] <= fin;
      end

      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      y_q <= measurement_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= opa * opb;
    end
    if (state_q == ST_ACC) begin
      acc_q <= (uop.first ? 66'sd0 : acc_q) + 66'(prod_q);
    end
    if (state_q == ST_WB && uop.dst == kfs_pkg::DST_S) begin
      s_q <= fin;
    end
    if (state_q == ST_RD && uop.kind == kfs_pkg::OP_DIV) begin
      dvs_q <= s_q[31] ? 32'(-s_q) : 32'(s_q);
      rem_q <= '0;
      quo_q <= '0;
    end
    if (state_q == ST_DIV) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= 32'(trial - {1'b0, dvs_q});
        quo_q <= {quo_q[31:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[31:0], 1'b0};
      end
    end
    if (state_q == ST_INV) begin
      inv_q <= inv_val;
    end
    if (state_q == ST_OUT && out_free) begin
      estimate_0_o   <= x_q[0];
      estimate_1_o   <= x_q[1];
      elapsed_time_o <= time_q;
      not_ready_o    <= nr_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/kfs_ram.sv -----
// Generic dual read port RAM with registered read data.
module kfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- tb/kalman_filter_step_tb.sv -----
// Self-checking testbench for the fixed point Kalman filter step block.
module kalman_filter_step_tb;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 1500;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] meas;
    logic signed [15:0] s0;
    logic signed [15:0] s1;
    logic [31:0]        t0;
  } filter_req_t;

  typedef struct {
    logic [31:0] est0;
    logic [31:0] est1;
    logic [31:0] etime;
    logic        nrdy;
  } filter_res_t;

  class kf_scoreboard;
    logic [63:0] trans, mrow, pnoise, icov;
    logic [15:0] rnoise, tstep;
    longint      xs[2];
    longint      pc[4];
    logic [31:0] now, saved;
    bit          ready;
    filter_res_t expected_estimates[$];
    int          n_fail, n_checked, n_measure, n_not_ready, n_zero_gain;

    function new();
      trans = '0; mrow = '0; pnoise = '0; icov = '0;
      rnoise = 16'd256; tstep = 16'd256;
      xs = '{0, 0}; pc = '{0, 0, 0, 0};
      now = '0; saved = '0; ready = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        kfs_pkg::CFG_TRANSITION: trans = d;
        kfs_pkg::CFG_MEAS_ROW:   mrow = d[31:0];
        kfs_pkg::CFG_PROC_NOISE: pnoise = d;
        kfs_pkg::CFG_MEAS_NOISE: rnoise = d[15:0];
        kfs_pkg::CFG_INIT_COV:   icov = d;
        kfs_pkg::CFG_TIME_STEP:  tstep = d[15:0];
        default: ;
      endcase
    endfunction

    function longint ent(logic [63:0] w, int k);
      logic [15:0] e;
      e = w[16*k +: 16];
      return longint'($signed(e));
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void load(longint a, longint b, logic [31:0] t);
      xs[0] = sat(a * 256);
      xs[1] = sat(b * 256);
      for (int i = 0; i < 4; i++) pc[i] = sat(ent(icov, i) * 256);
      saved = t;
      now = t;
      ready = 1;
    endfunction

    function void update(longint y);
      longint a[4], c[2], xp[2], tm[4], pp[4], h[2], kg[2], m[4];
      longint s, inv, r;
      for (int i = 0; i < 4; i++) a[i] = ent(trans, i);
      c[0] = ent({32'd0, mrow}, 0);
      c[1] = ent({32'd0, mrow}, 1);
      for (int i = 0; i < 2; i++) xp[i] = sat((a[2*i]*xs[0] + a[2*i+1]*xs[1]) >>> 8);
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          tm[2*i+j] = sat((a[2*i]*pc[j] + a[2*i+1]*pc[2+j]) >>> 8);
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          pp[2*i+j] = sat(((tm[2*i]*a[2*j] + tm[2*i+1]*a[2*j+1]) >>> 8)
                          + ent(pnoise, 2*i+j) * 256);
      for (int i = 0; i < 2; i++) h[i] = sat((pp[2*i]*c[0] + pp[2*i+1]*c[1]) >>> 8);
      s = sat(((c[0]*h[0] + c[1]*h[1]) >>> 8) + longint'(rnoise) * 256);
      if (s == 0) n_zero_gain++;
      inv = (s == 0) ? 0 : sat((64'sd1 <<< 32) / s);
      for (int i = 0; i < 2; i++) kg[i] = sat((h[i] * inv) >>> 16);
      r = sat(y * 256 - ((c[0]*xp[0] + c[1]*xp[1]) >>> 8));
      for (int i = 0; i < 2; i++) xs[i] = sat(xp[i] + ((kg[i] * r) >>> 16));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          m[2*i+j] = sat((i == j ? 64'sd65536 : 64'sd0) - ((kg[i] * c[j]) >>> 8));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          pc[2*i+j] = sat((m[2*i]*pp[j] + m[2*i+1]*pp[2+j]) >>> 16);
      now = now + {8'd0, tstep, 8'd0};
    endfunction

    // Called for every accepted request transfer.
    function void note_request(filter_req_t q);
      filter_res_t e;
      e.nrdy = 1'b0;
      case (q.kind)
        kfs_pkg::REQ_MEASURE: begin
          if (ready) begin
            update(longint'(q.meas));
            n_measure++;
          end else begin
            e.nrdy = 1'b1;
            n_not_ready++;
          end
        end
        kfs_pkg::REQ_INIT: load(longint'(q.s0), longint'(q.s1), q.t0);
        kfs_pkg::REQ_RESTART: begin
          if (!ready) saved = '0;
          load(0, 0, saved);
        end
        default: ;
      endcase
      e.est0 = xs[0][31:0];
      e.est1 = xs[1][31:0];
      e.etime = now;
      expected_estimates.push_back(e);
    endfunction

    function void check_estimate(filter_res_t got);
      filter_res_t e;
      n_checked++;
      if (expected_estimates.size() == 0) begin
        $error("unexpected result transfer");
        n_fail++;
        return;
      end
      e = expected_estimates.pop_front();
      if (got.est0 !== e.est0) begin
        $error("estimate_0 expected %h actual %h", e.est0, got.est0);
        n_fail++;
      end
      if (got.est1 !== e.est1) begin
        $error("estimate_1 expected %h actual %h", e.est1, got.est1);
        n_fail++;
      end
      if (got.etime !== e.etime) begin
        $error("elapsed_time expected %h actual %h", e.etime, got.etime);
        n_fail++;
      end
      if (got.nrdy !== e.nrdy) begin
        $error("not_ready expected %b actual %b", e.nrdy, got.nrdy);
        n_fail++;
      end
    endfunction

    function int pending();
      return expected_estimates.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [63:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         req_type_i;
  logic signed [15:0] measurement_i;
  logic signed [15:0] initial_state_0_i;
  logic signed [15:0] initial_state_1_i;
  logic [31:0]        start_time_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] estimate_0_o;
  logic signed [31:0] estimate_1_o;
  logic [31:0]        elapsed_time_o;
  logic               not_ready_o;

  kalman_filter_step u_dut (.*);

  kf_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_tag;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: checks each transfer, then picks the stall for the next cycle.
  initial begin : result_side
    int seen_tag;
    int hold_left;
    filter_res_t got;
    seen_tag = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.est0 = estimate_0_o;
        got.est1 = estimate_1_o;
        got.etime = elapsed_time_o;
        got.nrdy = not_ready_o;
        sb.check_estimate(got);
      end
      if (hold_tag != seen_tag) begin
        seen_tag = hold_tag;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  task automatic write_all(logic [63:0] a, logic [31:0] c, logic [63:0] q, logic [15:0] r,
                           logic [63:0] p0, logic [15:0] ts);
    write_reg(kfs_pkg::CFG_TRANSITION, a);
    write_reg(kfs_pkg::CFG_MEAS_ROW, {32'd0, c});
    write_reg(kfs_pkg::CFG_PROC_NOISE, q);
    write_reg(kfs_pkg::CFG_MEAS_NOISE, {48'd0, r});
    write_reg(kfs_pkg::CFG_INIT_COV, p0);
    write_reg(kfs_pkg::CFG_TIME_STEP, {48'd0, ts});
  endtask

  // Holds valid across back-to-back transfers; lowers it only for an idle gap.
  task automatic send_req(filter_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= q.kind;
    measurement_i <= q.meas;
    initial_state_0_i <= q.s0;
    initial_state_1_i <= q.s1;
    start_time_i <= q.t0;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(q);
  endtask

  function automatic filter_req_t mk(logic [1:0] k, logic [15:0] y, logic [15:0] a,
                                     logic [15:0] b, logic [31:0] t);
    filter_req_t q;
    q.kind = k; q.meas = y; q.s0 = a; q.s1 = b; q.t0 = t;
    return q;
  endfunction

  function automatic filter_req_t random_req();
    int pick;
    logic [1:0] k;
    logic [15:0] y;
    pick = $urandom_range(99);
    if (pick < 72) k = kfs_pkg::REQ_MEASURE;
    else if (pick < 86) k = kfs_pkg::REQ_INIT;
    else if (pick < 95) k = kfs_pkg::REQ_RESTART;
    else k = REQ_IGNORED;
    y = 16'($urandom);
    if ($urandom_range(9) == 0) y = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    return mk(k, y, 16'($urandom), 16'($urandom), $urandom);
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    measurement_i = '0;
    initial_state_0_i = '0;
    initial_state_1_i = '0;
    start_time_i = '0;
    out_stall_i = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_tag = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before initialization: measurement flags not ready, restart uses a zero start time.
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h0100, 0, 0, 0));
    send_req(mk(REQ_IGNORED, 0, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_RESTART, 0, 0, 0, 32'h1234_5678));
    drain();
    write_all(64'h0100_0000_0100_0100, 32'h0000_0100, 64'h0010_0000_0000_0010, 16'h0100,
              64'h0100_0000_0000_0100, 16'h0100);
    send_req(mk(kfs_pkg::REQ_INIT, 0, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h7FFF, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h8000, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h0000, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_RESTART, 0, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h0280, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_INIT, 0, 16'h8000, 16'h7FFF, 32'h0));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'hFF00, 0, 0, 0));
    drain();
    // Zero measurement row and noise give a zero innovation variance.
    write_all(64'h0100_0000_0080_0100, 32'h0, 64'h0100_0000_0000_0100, 16'h0,
              64'h0200_0000_0000_0200, 16'h0000);
    send_req(mk(kfs_pkg::REQ_INIT, 0, 16'h0100, 16'hFF00, 32'h0001_0000));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h7FFF, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h8000, 0, 0, 0));
    drain();
    write_all(64'h8000_7FFF_8000_7FFF, 32'h7FFF_8000, 64'h7FFF_8000_8000_7FFF, 16'hFFFF,
              64'h7FFF_8000_7FFF_7FFF, 16'hFFFF);
    send_req(mk(kfs_pkg::REQ_INIT, 0, 16'h7FFF, 16'h7FFF, 32'hFFFF_0000));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h7FFF, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h8000, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_MEASURE, 16'h1234, 0, 0, 0));
    send_req(mk(REQ_IGNORED, 0, 0, 0, 0));
    send_req(mk(kfs_pkg::REQ_RESTART, 0, 0, 0, 0));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph % 2 == 0)
        write_all({16'h0100, 16'($urandom_range(255)), 16'h0000, 16'h0100},
                  {16'h0000, 16'h0100}, {16'($urandom_range(63)), 32'h0, 16'($urandom_range(63))},
                  16'($urandom_range(1024)), {16'h0400, 32'h0, 16'h0400}, 16'($urandom));
      else
        write_all({$urandom, $urandom}, $urandom, {$urandom, $urandom}, 16'($urandom),
                  {$urandom, $urandom}, 16'($urandom));
      case (ph / 2)
        0: begin send_idle_pct = 8; recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 8; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 4) begin
        // Long receiver hold-off while requests keep coming, then wait for all results.
        hold_tag = hold_tag + 1;
        send_req(mk(kfs_pkg::REQ_INIT, 0, 16'($urandom), 16'($urandom), $urandom));
        repeat (10) send_req(random_req());
        drain();
      end
      repeat (88) send_req(random_req());
    end
    drain();
    repeat (300) @(posedge clk_i);

    $display("Checked %0d results: %0d measurement updates, %0d not-ready flags,",
             sb.n_checked, sb.n_measure, sb.n_not_ready);
    $display("%0d zero-gain updates, six register settings under three idle patterns.",
             sb.n_zero_gain);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #16000000;
    $display("status: fail");
    $finish;
  end

endmodule
